>>> src/wcs_pkg.sv
// ============================================================================
// wcs_pkg
// Shared types and constants for the window class histogram scorer: field
// widths, class codes, register indexes and the controller-to-datapath command.
// ============================================================================
package wcs_pkg;

  // Field and storage widths
  localparam int PIX_W       = 8;
  localparam int COUNT_W     = 12;
  localparam int TOTAL_W     = 14;
  localparam int FRAC_W      = 17;
  localparam int CFG_W       = 17;
  localparam int CFG_IDX_W   = 2;
  localparam int PROD_W      = 2 * FRAC_W;
  localparam int TOL_W       = PROD_W + 1;
  localparam int NUM_CLASS   = 4;
  localparam int CLASS_IDX_W = 2;
  localparam int VOTE_W      = 3;
  localparam int VOTE_SHIFT  = 14;

  // Stream payload widths, padded to whole bytes
  localparam int S_TDATA_W = 40;
  localparam int M_TDATA_W = 24;

  // Window geometry
  localparam int WINDOW_SIDE_DEF = 40;
  localparam int COUNT_CAP_MAX   = 4095;

  // Fraction divider: one quotient bit per cycle, 17 bits per class
  localparam int DIV_STEPS  = 17;
  localparam int DIV_STEP_W = 5;

  // Score limits, Q1.16: other above 0.8, class two above 0.9
  localparam logic [FRAC_W-1:0] OTHER_LIMIT       = 17'd52428;
  localparam logic [FRAC_W-1:0] CH2_LIMIT         = 17'd58982;
  localparam logic [FRAC_W-1:0] SCORE_POINT_EIGHT = 17'd52429;

  // Register reset values
  localparam logic [CFG_W-1:0] ABS_RESET    = 17'd5243;
  localparam logic [CFG_W-1:0] REL_RESET    = 17'd5243;
  localparam logic [CFG_W-1:0] ACCEPT_RESET = 17'd36045;
  localparam logic [PIX_W-1:0] FLOOR_RESET  = 8'd5;

  // Class codes
  localparam logic [CLASS_IDX_W-1:0] CLS_CH0   = 2'd0;
  localparam logic [CLASS_IDX_W-1:0] CLS_CH1   = 2'd1;
  localparam logic [CLASS_IDX_W-1:0] CLS_CH2   = 2'd2;
  localparam logic [CLASS_IDX_W-1:0] CLS_OTHER = 2'd3;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ABS    = 2'd0,
    REG_REL    = 2'd1,
    REG_ACCEPT = 2'd2,
    REG_FLOOR  = 2'd3
  } cfg_reg_e;

  // Four Q1.16 fractions, one per class
  typedef logic [NUM_CLASS-1:0][FRAC_W-1:0] frac_vec_t;

  // Controller to datapath command
  typedef struct packed {
    logic                   pix_en;
    logic                   sum_en;
    logic                   div_en;
    logic                   div_first;
    logic                   div_last;
    logic [CLASS_IDX_W-1:0] div_idx;
    logic                   tol_en;
    logic                   score_en;
    logic                   ref_seed;
    logic                   out_load;
  } wcs_cmd_t;

endpackage

>>> src/wcs_dp.sv
// ============================================================================
// wcs_dp
// Datapath: configuration registers, class counters, serial fraction divider,
// tolerance multiplier, window scoring and the result register.
// ============================================================================
module wcs_dp #(
  parameter int WINDOW_SIDE = wcs_pkg::WINDOW_SIDE_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [wcs_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [wcs_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          in_bounds_i,
  input  logic [wcs_pkg::PIX_W-1:0]     lightness_i,
  input  logic [wcs_pkg::PIX_W-1:0]     chan_zero_i,
  input  logic [wcs_pkg::PIX_W-1:0]     chan_one_i,
  input  logic [wcs_pkg::PIX_W-1:0]     chan_two_i,
  input  logic                          mode_i,
  input  logic                          last_i,
  input  wcs_pkg::wcs_cmd_t             cmd_i,
  output logic [wcs_pkg::FRAC_W-1:0]    score_o,
  output logic                          accept_o
);
  import wcs_pkg::*;

  localparam int AREA    = WINDOW_SIDE * WINDOW_SIDE;
  localparam int CAP_INT = (AREA < COUNT_CAP_MAX) ? AREA : COUNT_CAP_MAX;
  localparam logic [COUNT_W-1:0] COUNT_CAP = COUNT_W'(CAP_INT);

  // Configuration registers
  logic [CFG_W-1:0] abs_q, rel_q, accept_thr_q;
  logic [PIX_W-1:0] floor_q;

  // Window state
  logic [NUM_CLASS-1:0][COUNT_W-1:0] count_q;
  frac_vec_t                         frac_q, seed_q, prev_q;
  logic                              mode_q;
  logic [TOTAL_W-1:0]                total_q;

  // Divider
  logic [TOTAL_W-1:0] rem_q;
  logic [FRAC_W-1:0]  quo_q;
  logic [TOTAL_W:0]   trial;
  logic               trial_ge;
  logic [TOTAL_W:0]   trial_sub;
  logic [FRAC_W-1:0]  quo_next;

  // Scoring
  frac_vec_t          ref_prev, ref_seed, ref_sel;
  logic [PROD_W-1:0]  prod;
  logic [TOL_W-1:0]   tol_d, tol_q;
  logic [FRAC_W-1:0]  score_cur;
  logic [FRAC_W-1:0]  s_prev_q, s_seed_q, best;
  logic [FRAC_W-1:0]  score_q;
  logic               accept_q;

  // Pixel classification
  logic                   cls_valid;
  logic [CLASS_IDX_W-1:0] cls;

  // Score one window against a reference with full or half tolerance
  function automatic logic [FRAC_W-1:0] score_fn(input frac_vec_t r, input frac_vec_t c,
                                                 input logic [TOL_W-1:0] tol,
                                                 input logic half);
    logic [FRAC_W-1:0] d;
    logic [TOL_W-1:0]  dsh;
    logic [VOTE_W-1:0] votes;
    logic [FRAC_W-1:0] res;
    votes = '0;
    for (int i = 0; i < NUM_CLASS; i++) begin
      d   = (r[i] > c[i]) ? (r[i] - c[i]) : (c[i] - r[i]);
      dsh = half ? {1'b0, d, 17'b0} : {2'b0, d, 16'b0};
      if (dsh < tol) begin
        votes = votes + VOTE_W'(1);
      end
    end
    if (c[CLS_OTHER] > OTHER_LIMIT || r[CLS_OTHER] > OTHER_LIMIT) begin
      res = '0;
    end else if (c[CLS_CH2] > CH2_LIMIT || r[CLS_CH2] > CH2_LIMIT) begin
      res = SCORE_POINT_EIGHT;
    end else begin
      res = {votes, {VOTE_SHIFT{1'b0}}};
    end
    return res;
  endfunction

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      abs_q        <= ABS_RESET;
      rel_q        <= REL_RESET;
      accept_thr_q <= ACCEPT_RESET;
      floor_q      <= FLOOR_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_ABS:    abs_q        <= cfg_data_i;
        REG_REL:    rel_q        <= cfg_data_i;
        REG_ACCEPT: accept_thr_q <= cfg_data_i;
        REG_FLOOR:  floor_q      <= cfg_data_i[PIX_W-1:0];
        default:    ;
      endcase
    end
  end

  // Classify the incoming pixel: other first, then first channel above floor
  always_comb begin
    cls_valid = 1'b0;
    cls       = CLS_OTHER;
    if (in_bounds_i) begin
      priority if (lightness_i == '0) begin
        cls_valid = 1'b1;
        cls       = CLS_OTHER;
      end else if (chan_zero_i > floor_q) begin
        cls_valid = 1'b1;
        cls       = CLS_CH0;
      end else if (chan_one_i > floor_q) begin
        cls_valid = 1'b1;
        cls       = CLS_CH1;
      end else if (chan_two_i > floor_q) begin
        cls_valid = 1'b1;
        cls       = CLS_CH2;
      end
    end
  end

  // Count classes, saturate at the cap, clear when the result is loaded
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.out_load) begin
      count_q <= '0;
    end else if (cmd_i.pix_en && cls_valid && count_q[cls] < COUNT_CAP) begin
      count_q[cls] <= count_q[cls] + COUNT_W'(1);
    end
  end

  // Latch mode on the last pixel and the window total
  always_ff @(posedge clk_i) begin
    if (cmd_i.pix_en && last_i) begin
      mode_q <= mode_i;
    end
    if (cmd_i.sum_en) begin
      total_q <= TOTAL_W'(count_q[0]) + TOTAL_W'(count_q[1])
               + TOTAL_W'(count_q[2]) + TOTAL_W'(count_q[3]);
    end
  end

  // One restoring division step: first step loads the count itself
  always_comb begin
    trial     = cmd_i.div_first ? (TOTAL_W+1)'(count_q[cmd_i.div_idx]) : {rem_q, 1'b0};
    trial_ge  = trial >= {1'b0, total_q};
    trial_sub = trial - {1'b0, total_q};
    quo_next  = {quo_q[FRAC_W-2:0], trial_ge};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_en) begin
      rem_q <= trial_ge ? trial_sub[TOTAL_W-1:0] : trial[TOTAL_W-1:0];
      quo_q <= quo_next;
      if (cmd_i.div_last) begin
        frac_q[cmd_i.div_idx] <= (total_q == '0) ? '0 : quo_next;
      end
    end
  end

  // Reference selection: a new seed window compares against itself
  assign ref_prev = mode_q ? frac_q : prev_q;
  assign ref_seed = mode_q ? frac_q : seed_q;
  assign ref_sel  = cmd_i.ref_seed ? ref_seed : ref_prev;

  // Tolerance: abs << 16 plus reference class-one fraction times rel
  assign prod      = ref_sel[CLS_CH1] * rel_q;
  assign tol_d     = {2'b0, abs_q, 16'b0} + TOL_W'(prod);
  assign score_cur = score_fn(ref_sel, frac_q, tol_q, !cmd_i.ref_seed);
  assign best      = (s_prev_q > s_seed_q) ? s_prev_q : s_seed_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.tol_en) begin
      tol_q <= tol_d;
    end
    if (cmd_i.score_en && !cmd_i.ref_seed) begin
      s_prev_q <= score_cur;
    end
    if (cmd_i.score_en && cmd_i.ref_seed) begin
      s_seed_q <= score_cur;
    end
    if (cmd_i.out_load) begin
      score_q  <= best;
      accept_q <= best >= accept_thr_q;
    end
  end

  // Advance reference windows when the result is loaded
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
      prev_q <= '0;
    end else if (cmd_i.out_load) begin
      prev_q <= frac_q;
      if (mode_q) begin
        seed_q <= frac_q;
      end
    end
  end

  assign score_o  = score_q;
  assign accept_o = accept_q;

endmodule

>>> src/wcs_ctrl.sv
// ============================================================================
// wcs_ctrl
// Controller: sequences pixel intake, window total, serial division, the two
// scoring passes and the result hand-off.
// ============================================================================
module wcs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  input  logic              s_last_i,
  output logic              s_ready_o,
  output logic              m_valid_o,
  input  logic              m_ready_i,
  output wcs_pkg::wcs_cmd_t cmd_o
);
  import wcs_pkg::*;

  typedef enum logic [2:0] {
    ST_ACCUM,
    ST_SUM,
    ST_DIVIDE,
    ST_TOLP,
    ST_SCRP,
    ST_TOLS,
    ST_SCRS,
    ST_EMIT
  } state_e;

  localparam logic [DIV_STEP_W-1:0]  STEP_LAST  = DIV_STEP_W'(DIV_STEPS - 1);
  localparam logic [CLASS_IDX_W-1:0] CLASS_LAST = CLASS_IDX_W'(NUM_CLASS - 1);

  state_e                 state_q;
  logic [CLASS_IDX_W-1:0] div_idx_q;
  logic [DIV_STEP_W-1:0]  div_step_q;
  logic                   out_valid_q;
  logic                   pix_acc;
  logic                   out_free;
  wcs_cmd_t               cmd;

  assign pix_acc  = s_valid_i && (state_q == ST_ACCUM);
  assign out_free = !out_valid_q || m_ready_i;

  // Decode commands from the current state
  always_comb begin
    cmd           = '0;
    cmd.pix_en    = pix_acc;
    cmd.div_idx   = div_idx_q;
    cmd.div_first = (div_step_q == '0);
    cmd.div_last  = (div_step_q == STEP_LAST);
    unique case (state_q)
      ST_ACCUM:  ;
      ST_SUM:    cmd.sum_en = 1'b1;
      ST_DIVIDE: cmd.div_en = 1'b1;
      ST_TOLP:   cmd.tol_en = 1'b1;
      ST_SCRP:   cmd.score_en = 1'b1;
      ST_TOLS: begin
        cmd.tol_en   = 1'b1;
        cmd.ref_seed = 1'b1;
      end
      ST_SCRS: begin
        cmd.score_en = 1'b1;
        cmd.ref_seed = 1'b1;
      end
      ST_EMIT:   cmd.out_load = out_free;
      default:   ;
    endcase
  end

  // Hold state, divider counters and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_ACCUM;
      div_idx_q   <= '0;
      div_step_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_ACCUM: begin
          if (pix_acc && s_last_i) begin
            state_q <= ST_SUM;
          end
        end
        ST_SUM: begin
          div_idx_q  <= '0;
          div_step_q <= '0;
          state_q    <= ST_DIVIDE;
        end
        ST_DIVIDE: begin
          if (div_step_q == STEP_LAST) begin
            div_step_q <= '0;
            div_idx_q  <= div_idx_q + CLASS_IDX_W'(1);
            if (div_idx_q == CLASS_LAST) begin
              state_q <= ST_TOLP;
            end
          end else begin
            div_step_q <= div_step_q + DIV_STEP_W'(1);
          end
        end
        ST_TOLP: state_q <= ST_SCRP;
        ST_SCRP: state_q <= ST_TOLS;
        ST_TOLS: state_q <= ST_SCRS;
        ST_SCRS: state_q <= ST_EMIT;
        ST_EMIT: begin
          if (out_free) begin
            state_q <= ST_ACCUM;
          end
        end
        default: state_q <= ST_ACCUM;
      endcase
    end
  end

  assign s_ready_o = (state_q == ST_ACCUM);
  assign m_valid_o = out_valid_q;
  assign cmd_o     = cmd;

`ifndef NO_ASSERTIONS
  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIVIDE |-> div_step_q <= STEP_LAST)
    else $error("divider step counter out of range");

  a_sum_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SUM |-> $past(state_q == ST_ACCUM && s_valid_i && s_last_i))
    else $error("window closed without an accepted last pixel");

  a_div_complete: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_TOLP |->
      $past(state_q == ST_DIVIDE && div_idx_q == CLASS_LAST && div_step_q == STEP_LAST))
    else $error("scoring started before all fractions were divided");

  a_emit_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT && out_valid_q && !m_ready_i |=> state_q == ST_EMIT)
    else $error("result dropped while output register was full");

  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |=> m_valid_o)
    else $error("loaded result not presented");
`endif

endmodule

>>> src/window_class_histogram_scorer.sv
// ============================================================================
// window_class_histogram_scorer
// Classifies the pixels of a square window, turns the class counts into
// Q1.16 fractions and scores the window against the previous and seed windows.
// ============================================================================
// Pixels enter at one per clock while the block is counting. The transaction
// with tlast closes the window; s_axis_tready then stays low while the block
// totals the counts, runs the bit-serial divider (17 quotient bits for
// each of the four classes), uses the shared tolerance multiplier for the
// two scoring passes and loads the result register, and longer if the
// previous result has not yet been taken. The next window's pixels are
// accepted while the result waits on the master side.
module window_class_histogram_scorer #(
  parameter int WINDOW_SIDE = wcs_pkg::WINDOW_SIDE_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write port
  input  logic                          cfg_we_i,
  input  logic [wcs_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [wcs_pkg::CFG_W-1:0]     cfg_data_i,
  // Pixel stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [0] in_bounds, [8:1] lightness, [16:9] chan_zero, [24:17] chan_one,
  // [32:25] chan_two, [39:33] zero
  input  logic [wcs_pkg::S_TDATA_W-1:0] s_axis_tdata,
  input  logic                          s_axis_tuser,  // [0] mode
  input  logic                          s_axis_tlast,  // last_pixel
  // Result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [16:0] score, [17] accept, [23:18] zero
  output logic [wcs_pkg::M_TDATA_W-1:0] m_axis_tdata
);
  import wcs_pkg::*;

  wcs_cmd_t          cmd;
  logic [FRAC_W-1:0] score;
  logic              accept;

  wcs_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_last_i  (s_axis_tlast),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .cmd_o     (cmd)
  );

  wcs_dp #(
    .WINDOW_SIDE (WINDOW_SIDE)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_bounds_i (s_axis_tdata[0]),
    .lightness_i (s_axis_tdata[8:1]),
    .chan_zero_i (s_axis_tdata[16:9]),
    .chan_one_i  (s_axis_tdata[24:17]),
    .chan_two_i  (s_axis_tdata[32:25]),
    .mode_i      (s_axis_tuser),
    .last_i      (s_axis_tlast),
    .cmd_i       (cmd),
    .score_o     (score),
    .accept_o    (accept)
  );

  // Pack the result
  assign m_axis_tdata = {{(M_TDATA_W - FRAC_W - 1){1'b0}}, accept, score};

endmodule

>>> bench/tb.sv
// ============================================================================
// Window class histogram scorer testbench
// Streams pixel windows into the scorer and predicts each window's score
// and accept flag. Covers the reset and extreme register settings, then
// random ones, with random idle and stall gaps on both streams.
// ============================================================================
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wcs_pkg::*;

  localparam int WIN_SIDE     = 40;
  localparam int TALLY_CAP    = (WIN_SIDE * WIN_SIDE < COUNT_CAP_MAX) ?
                                WIN_SIDE * WIN_SIDE : COUNT_CAP_MAX;
  localparam int QUARTER_Q16  = 16384;
  localparam int ONE_Q16      = 65536;
  localparam int DRAIN_CYCLES = 100;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int LONG_HOLD    = 400;
  localparam int NUM_KINDS    = 7;

  // Pixel flavors the generator can produce
  typedef enum int {
    K_CH0, K_CH1, K_CH2, K_OTHER, K_BLANK, K_OUTSIDE, K_NOISE
  } pix_kind_e;

  typedef struct {
    logic       in_bounds;
    logic [7:0] light;
    logic [7:0] ch0;
    logic [7:0] ch1;
    logic [7:0] ch2;
    logic       mode;
    logic       last;
  } pixel_t;

  typedef struct packed {
    logic [FRAC_W-1:0] score;
    logic              accept;
  } verdict_t;

  // Tracks class tallies and reference fractions, predicts window verdicts
  class score_tracker;
    logic [CFG_W-1:0] abs_thr;
    logic [CFG_W-1:0] rel_thr;
    logic [CFG_W-1:0] acc_thr;
    logic [PIX_W-1:0] floor_lvl;
    int unsigned      tally[4];
    int unsigned      seed_frac[4];
    int unsigned      prior_frac[4];
    verdict_t         pending_verdicts[$];
    int unsigned      pixels;
    int unsigned      windows;
    int unsigned      accepted;
    int unsigned      fails;

    function new();
      abs_thr    = ABS_RESET;
      rel_thr    = REL_RESET;
      acc_thr    = ACCEPT_RESET;
      floor_lvl  = FLOOR_RESET;
      tally      = '{default: 0};
      seed_frac  = '{default: 0};
      prior_frac = '{default: 0};
      pixels     = 0;
      windows    = 0;
      accepted   = 0;
      fails      = 0;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_ABS:    abs_thr = val;
        REG_REL:    rel_thr = val;
        REG_ACCEPT: acc_thr = val;
        REG_FLOOR:  floor_lvl = val[PIX_W-1:0];
        default: ;
      endcase
    endfunction

    // Score one fraction set against a reference; half tightens tolerance
    function int unsigned rate_window(int unsigned basis[4], int unsigned cur[4],
                                      bit half);
      longint unsigned tol;
      longint unsigned diff;
      int unsigned     votes;
      votes = 0;
      if (cur[CLS_OTHER] * 5 > 4 * ONE_Q16 || basis[CLS_OTHER] * 5 > 4 * ONE_Q16)
        return 0;
      if (cur[CLS_CH2] * 10 > 9 * ONE_Q16 || basis[CLS_CH2] * 10 > 9 * ONE_Q16)
        return SCORE_POINT_EIGHT;
      tol = (longint'(abs_thr) << 16) + longint'(basis[CLS_CH1]) * longint'(rel_thr);
      for (int i = 0; i < NUM_CLASS; i++) begin
        diff = (basis[i] > cur[i]) ? longint'(basis[i] - cur[i])
                                   : longint'(cur[i] - basis[i]);
        diff = diff << (half ? 17 : 16);
        if (diff < tol) votes++;
      end
      return votes * QUARTER_Q16;
    endfunction

    // Classify one accepted pixel; close the window on the last one
    function void note_pixel(pixel_t p);
      bit          hit;
      logic [1:0]  cls;
      int unsigned total;
      int unsigned frac[4];
      int unsigned s_prior;
      int unsigned s_seed;
      int unsigned best;
      verdict_t    v;
      pixels++;
      hit = 1'b0;
      cls = CLS_OTHER;
      if (p.in_bounds) begin
        hit = 1'b1;
        if (p.light == 0) cls = CLS_OTHER;
        else if (p.ch0 > floor_lvl) cls = CLS_CH0;
        else if (p.ch1 > floor_lvl) cls = CLS_CH1;
        else if (p.ch2 > floor_lvl) cls = CLS_CH2;
        else hit = 1'b0;
      end
      if (hit && tally[cls] < TALLY_CAP) tally[cls]++;
      if (!p.last) return;

      total = tally[0] + tally[1] + tally[2] + tally[3];
      for (int i = 0; i < NUM_CLASS; i++)
        frac[i] = (total == 0) ? 0 : int'((longint'(tally[i]) << 16) / total);
      if (p.mode) begin
        seed_frac  = frac;
        prior_frac = frac;
      end
      s_prior = rate_window(prior_frac, frac, 1'b1);
      s_seed  = rate_window(seed_frac, frac, 1'b0);
      best    = (s_prior > s_seed) ? s_prior : s_seed;
      prior_frac = frac;
      tally      = '{default: 0};
      v.score  = best[FRAC_W-1:0];
      v.accept = (v.score >= acc_thr);
      pending_verdicts.push_back(v);
      windows++;
    endfunction

    function void check_result(logic [M_TDATA_W-1:0] beat);
      verdict_t want;
      if (pending_verdicts.size() == 0) begin
        $error("result with no window pending: score %0d accept %0d",
               beat[FRAC_W-1:0], beat[FRAC_W]);
        fails++;
        return;
      end
      want = pending_verdicts.pop_front();
      if (beat[FRAC_W-1:0] !== want.score) begin
        $error("score mismatch: expected %0d, got %0d", want.score, beat[FRAC_W-1:0]);
        fails++;
      end
      if (beat[FRAC_W] !== want.accept) begin
        $error("accept mismatch: expected %0d, got %0d", want.accept, beat[FRAC_W]);
        fails++;
      end
      if (want.accept) accepted++;
    endfunction

    function int pending();
      return pending_verdicts.size();
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata;
  logic                 s_axis_tuser;
  logic                 s_axis_tlast;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [M_TDATA_W-1:0] m_axis_tdata;

  score_tracker sb = new();
  bit           src_steady = 1'b0;
  int unsigned  settings = 1;

  window_class_histogram_scorer #(
    .WINDOW_SIDE(WIN_SIDE)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Pixel construction helpers
  function automatic pixel_t pix(logic ib, logic [7:0] lt, logic [7:0] c0,
                                 logic [7:0] c1, logic [7:0] c2, logic md, logic lst);
    pixel_t p;
    p.in_bounds = ib;
    p.light     = lt;
    p.ch0       = c0;
    p.ch1       = c1;
    p.ch2       = c2;
    p.mode      = md;
    p.last      = lst;
    return p;
  endfunction

  function automatic logic [7:0] above(logic [7:0] flr);
    return (flr == 8'd255) ? 8'd255 : 8'($urandom_range(255, int'(flr) + 1));
  endfunction

  function automatic logic [7:0] at_most(logic [7:0] flr);
    return 8'($urandom_range(int'(flr), 0));
  endfunction

  function automatic pixel_t make_pixel(pix_kind_e kind, logic [7:0] flr);
    pixel_t p;
    p = pix(1'b1, 8'($urandom_range(255, 1)), 8'($urandom_range(255, 0)),
            8'($urandom_range(255, 0)), 8'($urandom_range(255, 0)), 1'b0, 1'b0);
    case (kind)
      K_CH0: p.ch0 = above(flr);
      K_CH1: begin
        p.ch0 = at_most(flr);
        p.ch1 = above(flr);
      end
      K_CH2: begin
        p.ch0 = at_most(flr);
        p.ch1 = at_most(flr);
        p.ch2 = above(flr);
      end
      K_OTHER: p.light = 8'd0;
      K_BLANK: begin
        p.ch0 = at_most(flr);
        p.ch1 = at_most(flr);
        p.ch2 = at_most(flr);
      end
      K_OUTSIDE: p.in_bounds = 1'b0;
      default: begin
        p.in_bounds = 1'($urandom_range(1, 0));
        p.light     = 8'($urandom_range(255, 0));
      end
    endcase
    return p;
  endfunction

  function automatic pix_kind_e pick_kind(int w[NUM_KINDS]);
    int sum;
    int r;
    sum = 0;
    foreach (w[i]) sum += w[i];
    r = $urandom_range(sum - 1, 0);
    foreach (w[i]) begin
      if (r < w[i]) return pix_kind_e'(i);
      r -= w[i];
    end
    return K_NOISE;
  endfunction

  // Draw a class mix for a run of similar windows
  function automatic void make_profile(output int w[NUM_KINDS]);
    int style;
    w = '{default: 0};
    style = $urandom_range(9, 0);
    case (style)
      6: begin
        w[K_OTHER] = 20;
        w[K_CH0]   = $urandom_range(3, 0);
      end
      7: begin
        w[K_CH2] = 20;
        w[K_CH1] = $urandom_range(1, 0);
      end
      8: w[K_NOISE] = 1;
      9: begin
        w[K_BLANK]   = 1;
        w[K_OUTSIDE] = 1;
      end
      default: begin
        for (int i = K_CH0; i <= K_OTHER; i++) w[i] = $urandom_range(8, 0);
        w[K_BLANK]   = $urandom_range(2, 0);
        w[K_OUTSIDE] = $urandom_range(2, 0);
        w[K_NOISE]   = $urandom_range(1, 0);
        if (w[K_CH0] + w[K_CH1] + w[K_CH2] + w[K_OTHER] == 0) w[K_CH0] = 1;
      end
    endcase
  endfunction

  // Offer one pixel after a random gap; return at the accepting edge
  task automatic send_pixel(pixel_t p);
    int gap;
    gap = src_steady ? 0 : $urandom_range(12, 0);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, p.ch2, p.ch1, p.ch0, p.light, p.in_bounds};
    s_axis_tuser  <= p.mode;
    s_axis_tlast  <= p.last;
    do @(negedge clk_i); while (!s_axis_tready);
    @(posedge clk_i);
    sb.note_pixel(p);
  endtask

  task automatic send_window(int len, int w[NUM_KINDS], bit seed_mode);
    pixel_t p;
    src_steady = ($urandom_range(3, 0) == 0);
    for (int i = 0; i < len; i++) begin
      p      = make_pixel(pick_kind(w), sb.floor_lvl);
      p.last = (i == len - 1);
      p.mode = p.last ? seed_mode : 1'($urandom_range(1, 0));
      send_pixel(p);
    end
  endtask

  // Random windows in runs that share a class mix, so scores vary widely
  task automatic run_phase(int quota);
    int sent;
    int span;
    int len;
    int r;
    int w[NUM_KINDS];
    bit seed_mode;
    sent = 0;
    while (sent < quota) begin
      make_profile(w);
      span = $urandom_range(5, 1);
      for (int k = 0; k < span; k++) begin
        r   = $urandom_range(19, 0);
        len = (r < 13) ? $urandom_range(12, 1) :
              (r < 19) ? $urandom_range(40, 13) : $urandom_range(120, 41);
        seed_mode = (k == 0) ? ($urandom_range(9, 0) < 7) : ($urandom_range(9, 0) == 0);
        send_window(len, w, seed_mode);
        sent += len;
      end
    end
  endtask

  // Drop valid, wait for all verdicts, then let the back end go quiet
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    sb.set_reg(idx, val);
  endtask

  task automatic write_all(logic [CFG_W-1:0] abs_v, logic [CFG_W-1:0] rel_v,
                           logic [CFG_W-1:0] acc_v, logic [CFG_W-1:0] flr_v);
    settle();
    write_reg(REG_ABS, abs_v);
    write_reg(REG_REL, rel_v);
    write_reg(REG_ACCEPT, acc_v);
    write_reg(REG_FLOOR, flr_v);
    cfg_we_i <= 1'b0;
    settings++;
  endtask

  // Result side: random stalls, two long hold-offs to back up the block
  initial begin : result_sink
    logic [M_TDATA_W-1:0] beat;
    int                   stall;
    int                   taken;
    bit                   steady;
    taken  = 0;
    steady = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if ($urandom_range(7, 0) == 0) steady = ~steady;
      stall = steady ? 0 : $urandom_range(12, 0);
      if (taken == 3 || taken == 60) stall = LONG_HOLD;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(negedge clk_i); while (!m_axis_tvalid);
      beat = m_axis_tdata;
      @(posedge clk_i);
      sb.check_result(beat);
      taken++;
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    pixel_t           mix[6];
    int               acc_pick;
    logic [CFG_W-1:0] acc_v;
    logic [CFG_W-1:0] junk;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= REG_ABS;
    cfg_data_i    <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= 1'b0;
    s_axis_tlast  <= 1'b0;
    m_axis_tready <= 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty window: nothing counted, all fractions zero, new seed
    send_pixel(pix(1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1));
    // All "other": score forced to zero; mode off the last pixel is ignored
    send_pixel(pix(1'b1, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0));
    send_pixel(pix(1'b1, 8'h00, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b0));
    send_pixel(pix(1'b1, 8'h00, 8'h09, 8'h09, 8'h09, 1'b0, 1'b1));
    // All channel two: the 0.8 special score
    send_pixel(pix(1'b1, 8'h01, 8'h05, 8'h05, 8'h06, 1'b0, 1'b0));
    send_pixel(pix(1'b1, 8'hFF, 8'h00, 8'h00, 8'hFF, 1'b0, 1'b0));
    send_pixel(pix(1'b1, 8'h07, 8'h05, 8'h05, 8'hC8, 1'b0, 1'b1));
    // Mixed window at the floor boundary, once as seed and once repeated
    mix[0] = pix(1'b1, 8'h09, 8'h05, 8'h05, 8'h05, 1'b0, 1'b0);
    mix[1] = pix(1'b1, 8'h01, 8'h06, 8'h00, 8'h00, 1'b0, 1'b0);
    mix[2] = pix(1'b1, 8'h01, 8'h05, 8'h06, 8'h00, 1'b0, 1'b0);
    mix[3] = pix(1'b1, 8'h01, 8'h00, 8'h05, 8'h06, 1'b0, 1'b0);
    mix[4] = pix(1'b1, 8'h00, 8'h80, 8'h80, 8'h80, 1'b0, 1'b0);
    mix[5] = pix(1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1);
    foreach (mix[i]) send_pixel(mix[i]);
    mix[5].mode = 1'b0;
    foreach (mix[i]) send_pixel(mix[i]);
    // In-bounds pixels that fit no class
    send_pixel(pix(1'b1, 8'h80, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0));
    send_pixel(pix(1'b1, 8'h40, 8'h05, 8'h04, 8'h03, 1'b0, 1'b1));

    // Low extremes: zero tolerance, accept everything, any nonzero channel
    write_all(17'd0, 17'd0, 17'd0, 17'd0);
    run_phase(100);
    // High extremes: wide tolerance, no channel can pass the floor
    write_all(17'd65536, 17'd65536, 17'd65536, 17'd255);
    run_phase(100);
    // All register bits set, floor with upper data bits to be masked off
    write_all(17'h1FFFF, 17'h1FFFF, 17'h1FFFF, {9'h1FF, 8'd20});
    run_phase(100);

    for (int ph = 0; ph < 6; ph++) begin
      acc_pick = $urandom_range(4, 0);
      case (acc_pick)
        0:       acc_v = 17'd16384;
        1:       acc_v = 17'd32768;
        2:       acc_v = 17'd49152;
        3:       acc_v = 17'd65536;
        default: acc_v = 17'($urandom_range(65536, 0));
      endcase
      junk = 17'($urandom_range(17'h1FFFF, 0));
      write_all(17'($urandom_range(20000, 0)), 17'($urandom_range(65536, 0)), acc_v,
                {junk[16:8], 8'($urandom_range(60, 0))});
      run_phase(100);
    end

    write_all(ABS_RESET, REL_RESET, ACCEPT_RESET, 17'(FLOOR_RESET));
    run_phase(100);

    settle();
    $display("Run covered %0d pixels in %0d windows under %0d register settings.",
             sb.pixels, sb.windows, settings);
    $display("%0d windows were accepted, %0d check failures.", sb.accepted, sb.fails);
    if (sb.fails == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> files.f
src/wcs_pkg.sv
src/wcs_dp.sv
src/wcs_ctrl.sv
src/window_class_histogram_scorer.sv
bench/tb.sv
